### rtl/core/dsha_pkg.sv
// Package with SHA-256 constants, types and round functions for the double hash core.
package dsha_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned CompCount  = 3;

  typedef logic [31:0] word_t;
  typedef word_t [7:0]  state_t;
  typedef word_t [15:0] sched_t;

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam state_t InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Padding block for a 512-bit message; word 0 sits at index 0.
  localparam sched_t Pad512 = '{
    32'h00000200, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // Next schedule window: drop w[i-16], append w[i].
  function automatic sched_t sched_next(input sched_t w);
    word_t s0;
    word_t s1;
    sched_t r;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) r[i] = w[i+1];
    r[15] = w[0] + s0 + w[9] + s1;
    sched_next = r;
  endfunction

  // One compression round; v[0] is a, v[7] is h.
  function automatic state_t round_f(input state_t v, input word_t kw);
    word_t big1;
    word_t ch;
    word_t t1;
    word_t big0;
    word_t maj;
    state_t r;
    big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + big1 + ch + kw;
    big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    r[7] = v[6];
    r[6] = v[5];
    r[5] = v[4];
    r[4] = v[3] + t1;
    r[3] = v[2];
    r[2] = v[1];
    r[1] = v[0];
    r[0] = t1 + big0 + maj;
    round_f = r;
  endfunction

endpackage

### rtl/core/dsha_if.sv
// Valid/ready stream interfaces for message requests and digest results.
interface dsha_msg_if;
  logic              valid;
  logic              ready;
  logic [7:0][63:0]  block_word;
  modport source(output valid, output block_word, input ready);
  modport sink(input valid, input block_word, output ready);
endinterface

interface dsha_dig_if;
  logic              valid;
  logic              ready;
  logic [3:0][63:0]  digest_word;
  modport source(output valid, output digest_word, input ready);
  modport sink(input valid, input digest_word, output ready);
endinterface

### rtl/core/dsha_round.sv
// One pipelined SHA-256 round stage with its message schedule step.
module dsha_round
  import dsha_pkg::*;
#(
  parameter int unsigned RoundIdx = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   vld_in,
  input  state_t v_in,
  input  sched_t w_in,
  input  state_t h_in,
  output logic   vld_out,
  output state_t v_out,
  output sched_t w_out,
  output state_t h_out
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= round_f(v_in, RoundConst[RoundIdx] + w_in[0]);
      w_out <= sched_next(w_in);
      h_out <= h_in;
    end
  end

endmodule

### rtl/core/dsha_compress.sv
// Pipelined SHA-256 compression: sixty-four round stages, then a registered feed-forward add.
module dsha_compress
  import dsha_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   vld_in,
  input  state_t h_in,
  input  sched_t blk_in,
  output logic   vld_out,
  output state_t h_out
);

  logic   vld_s [RoundCount+1];
  state_t v_s   [RoundCount+1];
  sched_t w_s   [RoundCount+1];
  state_t h_s   [RoundCount+1];

  assign vld_s[0] = vld_in;
  assign v_s[0]   = h_in;
  assign w_s[0]   = blk_in;
  assign h_s[0]   = h_in;

  for (genvar g = 0; g < RoundCount; g++) begin : g_rnd
    dsha_round #(.RoundIdx(g)) u_rnd (
      .clk, .rst_n, .en,
      .vld_in(vld_s[g]), .v_in(v_s[g]), .w_in(w_s[g]), .h_in(h_s[g]),
      .vld_out(vld_s[g+1]), .v_out(v_s[g+1]), .w_out(w_s[g+1]), .h_out(h_s[g+1])
    );
  end

  // Feed-forward add is registered as a stage of its own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_s[RoundCount];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) h_out[i] <= h_s[RoundCount][i] + v_s[RoundCount][i];
    end
  end

  // The final schedule window is unused beyond this point.
  logic unused_w;
  assign unused_w = ^w_s[RoundCount];

endmodule

### rtl/core/double_sha256_64byte_block.sv
// Top level: three chained pipelined compressions computing SHA-256 of SHA-256.
// Each compression ends in a registered feed-forward add after its round stages.
// Throughput: one request per cycle while not stalled; each of the 192 round stages holds one item.
// The whole pipeline advances together and freezes while a result waits unclaimed
// and the output register is full, so a stall neither drops nor repeats anything.
// Reset (synchronous, rst_n low) clears every valid bit; data registers hold.
module double_sha256_64byte_block
  import dsha_pkg::*;
(
  input logic clk,
  input logic rst_n,
  dsha_msg_if.sink   in_msg,
  dsha_dig_if.source out_dig
);

  // The pipeline moves when the output stage is empty or being drained.
  logic en;
  assign en = !out_dig.valid || out_dig.ready;
  assign in_msg.ready = en;

  sched_t blk1;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk1[2*i]   = in_msg.block_word[i][63:32];
      blk1[2*i+1] = in_msg.block_word[i][31:0];
    end
  end

  logic   vld1;
  logic   vld2;
  state_t h1;
  state_t h2;
  state_t h3;
  sched_t blk3;

  dsha_compress u_c1 (
    .clk, .rst_n, .en, .vld_in(in_msg.valid), .h_in(InitHash), .blk_in(blk1),
    .vld_out(vld1), .h_out(h1)
  );

  dsha_compress u_c2 (
    .clk, .rst_n, .en, .vld_in(vld1), .h_in(h1), .blk_in(Pad512),
    .vld_out(vld2), .h_out(h2)
  );

  // The intermediate digest padded as a 256-bit message.
  always_comb begin
    for (int i = 0; i < 8; i++) blk3[i] = h2[i];
    for (int i = 8; i < 16; i++) blk3[i] = '0;
    blk3[8]  = 32'h80000000;
    blk3[15] = 32'h00000100;
  end

  dsha_compress u_c3 (
    .clk, .rst_n, .en, .vld_in(vld2), .h_in(InitHash), .blk_in(blk3),
    .vld_out(out_dig.valid), .h_out(h3)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) out_dig.digest_word[i] = {h3[2*i], h3[2*i+1]};
  end

  // A result held under back-pressure must not change.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_dig.valid && !out_dig.ready |=> $stable(out_dig.digest_word))
    else $error("digest changed under stall");
  // Input is refused exactly while a result waits.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_msg.ready == (!out_dig.valid || out_dig.ready))
    else $error("ready out of step with output stage");
  // Stalled pipeline keeps its inner valid bits.
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld1) && $stable(vld2))
    else $error("pipeline moved during stall");

endmodule

### verif/tb_double_sha256_64byte_block.sv
// Testbench for the double SHA-256 core: directed and random messages checked against a local predictor.
module tb_double_sha256_64byte_block;
  import dsha_pkg::*;

  // Clock and synchronous active-low reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dsha_msg_if in_msg();
  dsha_dig_if out_dig();

  double_sha256_64byte_block uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_msg(in_msg.sink),
    .out_dig(out_dig.source)
  );

  // Digests still owed by the core, oldest first.
  logic [3:0][63:0] pending_digests[$];
  int mismatch_count = 0;
  int unexpected_count = 0;
  int cycle_count = 0;
  int digests_seen = 0;

  // Idling control: when calm is set, neither side inserts gaps or stalls.
  bit calm = 1'b0;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 400;

  // Plain SHA-256 arithmetic, written independently of the package helpers.
  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Standard initial hash values, a first.
  function automatic logic [7:0][31:0] sha_start();
    logic [7:0][31:0] h;
    h[0] = 32'h6a09e667; h[1] = 32'hbb67ae85; h[2] = 32'h3c6ef372; h[3] = 32'ha54ff53a;
    h[4] = 32'h510e527f; h[5] = 32'h9b05688c; h[6] = 32'h1f83d9ab; h[7] = 32'h5be0cd19;
    return h;
  endfunction

  // One compression of a sixteen-word block into the running hash.
  function automatic logic [7:0][31:0] sha_compress(logic [7:0][31:0] h,
                                                   logic [15:0][31:0] blk);
    logic [31:0] w[64];
    logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = h[0]; b = h[1]; c = h[2]; d = h[3];
    e = h[4]; f = h[5]; g = h[6]; hh = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + RoundConst[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      hh = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d;
    h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
    return h;
  endfunction

  // SHA-256 applied twice to one 64-byte message, packed big-endian.
  function automatic logic [3:0][63:0] double_sha(logic [7:0][63:0] msg);
    logic [15:0][31:0] blk;
    logic [7:0][31:0] inner, outer;
    logic [3:0][63:0] dig;
    for (int i = 0; i < 8; i++) begin
      blk[2*i]   = msg[i][63:32];
      blk[2*i+1] = msg[i][31:0];
    end
    inner = sha_compress(sha_start(), blk);
    // The padding block for a 512-bit message.
    blk = '0;
    blk[0] = 32'h80000000;
    blk[15] = 32'h00000200;
    inner = sha_compress(inner, blk);
    // The inner digest padded as a 256-bit message.
    blk = '0;
    for (int i = 0; i < 8; i++) blk[i] = inner[i];
    blk[8] = 32'h80000000;
    blk[15] = 32'h00000100;
    outer = sha_compress(sha_start(), blk);
    for (int i = 0; i < 4; i++) dig[i] = {outer[2*i], outer[2*i+1]};
    return dig;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 33);
  endfunction

  // Send one message request: optional random gap, then hold valid until it is taken.
  // Valid is left high after acceptance; the idle path of the next call or end_requests lowers it.
  task automatic send_message(input logic [7:0][63:0] msg);
    while (idle_now()) begin
      in_msg.valid <= 1'b0;
      @(posedge clk);
    end
    in_msg.valid <= 1'b1;
    in_msg.block_word <= msg;
    @(posedge clk);
    while (!in_msg.ready) @(posedge clk);
    pending_digests.push_back(double_sha(msg));
  endtask

  task automatic end_requests();
    in_msg.valid <= 1'b0;
  endtask

  function automatic logic [7:0][63:0] random_message();
    logic [7:0][63:0] m;
    for (int i = 0; i < 8; i++) m[i] = {$urandom, $urandom};
    return m;
  endfunction

  // Result side: random stalls, and each digest taken is compared with the oldest owed.
  always @(posedge clk) begin
    logic [3:0][63:0] want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_dig.valid && out_dig.ready) begin
      digests_seen <= digests_seen + 1;
      if (pending_digests.size() == 0) begin
        unexpected_count <= unexpected_count + 1;
        if (mismatch_count + unexpected_count < 10)
          $display("Digest %h arrived with no request outstanding", out_dig.digest_word);
      end else begin
        want = pending_digests.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (out_dig.digest_word[i] !== want[i]) begin
            if (mismatch_count < 10)
              $display("Digest word %0d mismatch: expected %h, got %h",
                       i, want[i], out_dig.digest_word[i]);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
    end
    out_dig.ready <= !idle_now();
  end

  // Watchdog on the overall run length.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("double_sha256_64byte_block regression: fail");
      $finish;
    end
  end

  // Field extremes: all zeros, all ones, alternating patterns and walking ones.
  task automatic test_directed_extremes();
    logic [7:0][63:0] m;
    send_message('0);
    send_message('1);
    for (int i = 0; i < 8; i++) m[i] = 64'haaaaaaaaaaaaaaaa;
    send_message(m);
    for (int i = 0; i < 8; i++) m[i] = 64'h5555555555555555;
    send_message(m);
    for (int i = 0; i < 8; i++) m[i] = 64'h8000000000000001 << i;
    send_message(m);
    for (int i = 0; i < 8; i++) m[i] = 64'h1 << (63 - i);
    send_message(m);
    // Only the first byte set, then only the last byte set.
    m = '0; m[0] = 64'h8000000000000000;
    send_message(m);
    m = '0; m[7] = 64'h1;
    send_message(m);
    // Two identical halves, as when a tree node pairs a hash with itself.
    m = random_message();
    m[7:4] = m[3:0];
    send_message(m);
  endtask

  // Random messages at full rate, with neither side idling.
  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    repeat (count) send_message(random_message());
    calm = 1'b0;
  endtask

  // Random messages with gaps on both sides.
  task automatic test_random_traffic(input int count);
    repeat (count) send_message(random_message());
  endtask

  // Sender holds off until the pipeline has delivered every owed digest.
  task automatic test_drain_then_resume(input int count);
    end_requests();
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (count) send_message(random_message());
  endtask

  initial begin
    in_msg.valid = 1'b0;
    in_msg.block_word = '0;
    out_dig.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_back_to_back(120);
    test_random_traffic(150);
    test_drain_then_resume(20);
    test_random_traffic(150);
    end_requests();

    // Wait for every owed digest, then a little longer to catch stray results.
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && unexpected_count == 0 && pending_digests.size() == 0) begin
      $display("double_sha256_64byte_block regression: pass");
    end else begin
      $display("double_sha256_64byte_block regression: fail");
    end
    $finish;
  end

endmodule
